FILE: rtl/bfiq_pkg.sv
// Package: shared types, constants and state encoding for the Bloom filter core.
package bfiq_pkg;

    typedef struct packed {
        logic        command;
        logic [31:0] key_word;
        logic [2:0]  word_bytes;
        logic        last_word;
    } t_item;

    typedef struct packed {
        logic        is_member;
        logic [31:0] entry_count;
    } t_result;

    localparam int          CFG_W          = 17;
    localparam int          CFG_IDX_W      = 1;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_SIZE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HASH_COUNT = 1'b1;
    localparam logic [16:0] BIT_SIZE_RST   = 17'h10000;
    localparam logic [4:0]  HASH_COUNT_RST = 5'd7;

    localparam logic        CMD_INSERT = 1'b0;
    localparam logic        CMD_QUERY  = 1'b1;

    localparam logic [31:0] MM_C1   = 32'hcc9e2d51;
    localparam logic [31:0] MM_C2   = 32'h1b873593;
    localparam logic [31:0] MM_ADD  = 32'he6546b64;
    localparam logic [31:0] FMIX_C1 = 32'h85ebca6b;
    localparam logic [31:0] FMIX_C2 = 32'hc2b2ae35;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_K1, S_K2, S_MIX, S_F1, S_F2, S_DLD, S_DIV, S_RD, S_CHK, S_DONE
    } t_state;

    typedef enum logic [1:0] {
        MUL_K1, MUL_K2, MUL_F1, MUL_F2
    } t_mul_sel;

    typedef struct packed {
        logic     cap;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     mix;
        logic     div_load;
        logic     div_step;
        logic     mem_rd;
        logic     chk;
        logic     hnext;
        logic     clr_step;
        logic     finish;
    } t_ctrl;

    typedef struct packed {
        logic clr_done;
        logic last;
        logic probes_zero;
        logic div_last;
        logic hlast;
        logic miss;
    } t_stat;

endpackage

FILE: rtl/bfiq_ctrl.sv
// Controller: sequences word mixing, finalization, reduction and bit probes.
module bfiq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  bfiq_pkg::t_stat i_stat,
    output bfiq_pkg::t_ctrl o_ctrl,
    output logic            o_busy
);

    bfiq_pkg::t_state r_state;
    bfiq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bfiq_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            bfiq_pkg::S_CLEAR: if (i_stat.clr_done) n_state = bfiq_pkg::S_IDLE;
            bfiq_pkg::S_IDLE:  if (i_start) n_state = bfiq_pkg::S_K1;
            bfiq_pkg::S_K1:    n_state = bfiq_pkg::S_K2;
            bfiq_pkg::S_K2:    n_state = bfiq_pkg::S_MIX;
            bfiq_pkg::S_MIX: begin
                if (!i_stat.last)          n_state = bfiq_pkg::S_IDLE;
                else if (i_stat.probes_zero) n_state = bfiq_pkg::S_DONE;
                else                        n_state = bfiq_pkg::S_F1;
            end
            bfiq_pkg::S_F1:    n_state = bfiq_pkg::S_F2;
            bfiq_pkg::S_F2:    n_state = bfiq_pkg::S_DLD;
            bfiq_pkg::S_DLD:   n_state = bfiq_pkg::S_DIV;
            bfiq_pkg::S_DIV:   if (i_stat.div_last) n_state = bfiq_pkg::S_RD;
            bfiq_pkg::S_RD:    n_state = bfiq_pkg::S_CHK;
            bfiq_pkg::S_CHK: begin
                // a query stops at the first clear bit
                if (i_stat.miss || i_stat.hlast) n_state = bfiq_pkg::S_DONE;
                else                              n_state = bfiq_pkg::S_F1;
            end
            bfiq_pkg::S_DONE:  n_state = bfiq_pkg::S_IDLE;
            default:           n_state = bfiq_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        o_ctrl         = '0;
        o_ctrl.mul_sel = bfiq_pkg::MUL_K1;
        o_busy         = (r_state != bfiq_pkg::S_IDLE);
        case (r_state)
            bfiq_pkg::S_CLEAR: o_ctrl.clr_step = 1'b1;
            bfiq_pkg::S_IDLE:  o_ctrl.cap = i_start;
            bfiq_pkg::S_K1: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = bfiq_pkg::MUL_K1;
            end
            bfiq_pkg::S_K2: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = bfiq_pkg::MUL_K2;
            end
            bfiq_pkg::S_MIX:   o_ctrl.mix = 1'b1;
            bfiq_pkg::S_F1: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = bfiq_pkg::MUL_F1;
            end
            bfiq_pkg::S_F2: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = bfiq_pkg::MUL_F2;
            end
            bfiq_pkg::S_DLD:   o_ctrl.div_load = 1'b1;
            bfiq_pkg::S_DIV:   o_ctrl.div_step = 1'b1;
            bfiq_pkg::S_RD:    o_ctrl.mem_rd = 1'b1;
            bfiq_pkg::S_CHK: begin
                o_ctrl.chk   = 1'b1;
                o_ctrl.hnext = 1'b1;
            end
            bfiq_pkg::S_DONE:  o_ctrl.finish = 1'b1;
            default:           o_ctrl = '0;
        endcase
    end

endmodule

FILE: rtl/bfiq_dp.sv
// Datapath: hash lanes, shared multiplier, remainder unit, filter bit store, config.
module bfiq_dp #(
    parameter int FILTER_BITS = 65536,
    parameter int MAX_HASHES  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bfiq_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bfiq_pkg::CFG_W-1:0]        i_cfg_data,
    input  bfiq_pkg::t_item                   i_item,
    input  bfiq_pkg::t_ctrl                   i_ctrl,
    output bfiq_pkg::t_stat                   o_stat,
    output logic                              o_done,
    output bfiq_pkg::t_result                 o_result
);

    localparam int AW = $clog2(FILTER_BITS);
    localparam int MW = $clog2(FILTER_BITS + 1);
    localparam int HW = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
    localparam int PW = $clog2(MAX_HASHES + 1);

    logic [16:0]   r_bit_size;
    logic [4:0]    r_hcount;
    logic [31:0]   r_acc [MAX_HASHES];
    logic [31:0]   r_len;
    logic [31:0]   r_count;
    logic [31:0]   r_word;
    logic [2:0]    r_nb;
    logic          r_tail;
    logic          r_skip;
    logic          r_last;
    logic          r_cmd;
    logic [31:0]   r_prod;
    logic [31:0]   r_dvd;
    logic [MW-1:0] r_rem;
    logic [4:0]    r_dcnt;
    logic [PW-1:0] r_hidx;
    logic          r_member;
    logic          r_mem [FILTER_BITS];
    logic          r_rbit;
    logic [AW-1:0] r_caddr;
    logic          r_valid;
    logic          r_out_member;

    logic [31:0]   w_mod32;
    logic [MW-1:0] w_mod;
    logic [31:0]   w_prb32;
    logic [PW-1:0] w_probes;
    logic [2:0]    w_nbc;
    logic [31:0]   w_mask;
    logic [31:0]   w_x;
    logic [31:0]   w_mul_a;
    logic [31:0]   w_mul_b;
    logic [31:0]   w_prod;
    logic [MW:0]   w_trial;
    logic [AW-1:0] w_idx;

    // Murmur3 block round: xor, rotate left 13, times 5 plus constant
    function automatic logic [31:0] mm_round(logic [31:0] acc, logic [31:0] k);
        logic [31:0] h;
        h = acc ^ k;
        h = {h[18:0], h[31:19]};
        return (h << 2) + h + bfiq_pkg::MM_ADD;
    endfunction

    // config values clamped into range
    always_comb begin
        if (r_bit_size == 17'd0)                  w_mod32 = 32'd1;
        else if (32'(r_bit_size) > 32'(FILTER_BITS)) w_mod32 = 32'(FILTER_BITS);
        else                                       w_mod32 = 32'(r_bit_size);
        w_mod = w_mod32[MW-1:0];
        if (32'(r_hcount) > 32'(MAX_HASHES)) w_prb32 = 32'(MAX_HASHES);
        else                                 w_prb32 = 32'(r_hcount);
        w_probes = w_prb32[PW-1:0];
    end

    always_comb begin
        w_nbc = (i_item.word_bytes > 3'd4) ? 3'd4 : i_item.word_bytes;
        case (w_nbc)
            3'd0:    w_mask = 32'h0000_0000;
            3'd1:    w_mask = 32'h0000_00ff;
            3'd2:    w_mask = 32'h0000_ffff;
            3'd3:    w_mask = 32'h00ff_ffff;
            default: w_mask = 32'hffff_ffff;
        endcase
    end

    // shared multiplier, one product per cycle while mul_en is set
    always_comb begin
        w_x = r_acc[r_hidx[HW-1:0]] ^ r_len;
        case (i_ctrl.mul_sel)
            bfiq_pkg::MUL_K1: begin
                w_mul_a = r_word;
                w_mul_b = bfiq_pkg::MM_C1;
            end
            bfiq_pkg::MUL_K2: begin
                w_mul_a = {r_prod[16:0], r_prod[31:17]};
                w_mul_b = bfiq_pkg::MM_C2;
            end
            bfiq_pkg::MUL_F1: begin
                w_mul_a = w_x ^ (w_x >> 16);
                w_mul_b = bfiq_pkg::FMIX_C1;
            end
            bfiq_pkg::MUL_F2: begin
                w_mul_a = r_prod ^ (r_prod >> 13);
                w_mul_b = bfiq_pkg::FMIX_C2;
            end
            default: begin
                w_mul_a = r_word;
                w_mul_b = bfiq_pkg::MM_C1;
            end
        endcase
        w_prod = w_mul_a * w_mul_b;
    end

    assign w_trial = {r_rem, r_dvd[31]};
    assign w_idx   = r_rem[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_size <= bfiq_pkg::BIT_SIZE_RST;
            r_hcount   <= bfiq_pkg::HASH_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bfiq_pkg::REG_BIT_SIZE:   r_bit_size <= i_cfg_data[16:0];
                bfiq_pkg::REG_HASH_COUNT: r_hcount   <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // hash lanes and key length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.finish) begin
            for (int i = 0; i < MAX_HASHES; i++) r_acc[i] <= 32'(i);
            r_len <= '0;
        end else if (i_ctrl.mix && !r_skip) begin
            for (int i = 0; i < MAX_HASHES; i++) begin
                if (r_tail) begin
                    r_acc[i] <= r_acc[i] ^ r_prod;
                end else begin
                    r_acc[i] <= mm_round(r_acc[i], r_prod);
                end
            end
            r_len <= r_len + (r_tail ? 32'(r_nb) : 32'd4);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_valid  <= 1'b0;
            r_caddr  <= '0;
            r_hidx   <= '0;
            r_member <= 1'b1;
        end else begin
            r_valid <= 1'b0;
            if (i_ctrl.clr_step) r_caddr <= r_caddr + 1'b1;
            if (i_ctrl.cap) begin
                r_hidx   <= '0;
                r_member <= 1'b1;
            end
            if (i_ctrl.hnext) r_hidx <= r_hidx + 1'b1;
            if (i_ctrl.chk && o_stat.miss) r_member <= 1'b0;
            if (i_ctrl.finish) begin
                r_valid      <= 1'b1;
                r_out_member <= r_member;
                if (r_cmd == bfiq_pkg::CMD_INSERT && r_count != 32'hffff_ffff)
                    r_count <= r_count + 32'd1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.cap) begin
            r_cmd  <= i_item.command;
            r_last <= i_item.last_word;
            r_tail <= i_item.last_word && (w_nbc < 3'd4);
            r_skip <= i_item.last_word && (w_nbc == 3'd0);
            r_nb   <= w_nbc;
            r_word <= i_item.last_word ? (i_item.key_word & w_mask) : i_item.key_word;
        end
        if (i_ctrl.mul_en) r_prod <= w_prod;
        if (i_ctrl.div_load) begin
            r_dvd  <= r_prod ^ (r_prod >> 16);
            r_rem  <= '0;
            r_dcnt <= '0;
        end else if (i_ctrl.div_step) begin
            // restoring remainder, one bit a cycle
            r_dvd  <= r_dvd << 1;
            r_dcnt <= r_dcnt + 5'd1;
            if (w_trial >= {1'b0, w_mod}) r_rem <= MW'(w_trial - {1'b0, w_mod});
            else                          r_rem <= w_trial[MW-1:0];
        end
    end

    // filter bit store
    always_ff @(posedge i_clk) begin
        if (i_ctrl.clr_step) begin
            r_mem[r_caddr] <= 1'b0;
        end else if (i_ctrl.chk && r_cmd == bfiq_pkg::CMD_INSERT) begin
            r_mem[w_idx] <= 1'b1;
        end
        if (i_ctrl.mem_rd) r_rbit <= r_mem[w_idx];
    end

    always_comb begin
        o_stat.clr_done    = (r_caddr == AW'(FILTER_BITS - 1));
        o_stat.last        = r_last;
        o_stat.probes_zero = (w_probes == '0);
        o_stat.div_last    = (r_dcnt == 5'd31);
        o_stat.hlast       = (r_hidx == w_probes - 1'b1);
        o_stat.miss        = (r_cmd == bfiq_pkg::CMD_QUERY) && !r_rbit;
    end

    assign o_done               = r_valid;
    assign o_result.is_member   = r_out_member;
    assign o_result.entry_count = r_count;

endmodule

FILE: rtl/bloom_filter_insert_query_core.sv
// Top level: Bloom filter with streamed keys and seeded Murmur3 probes.
//
//  port group        dir  timing
//  i_start/i_item    in   word taken when i_start && !o_busy
//  i_cfg_*           in   register write on any edge with i_cfg_we
//  o_done/o_result   out  one-cycle strobe, cannot be held off
//
// A non-last key word takes two multiplier passes on the shared 32x32
// multiplier, then the lane update. A last word also runs each probe in turn,
// then a done step; each probe is two fmix multiplies, a 32-step restoring remainder
// and a read/write of the bit store. A query ends at the first clear bit.
// After reset o_busy stays high while the bit store is swept to zero;
// register writes are still taken then.
module bloom_filter_insert_query_core #(
    parameter int FILTER_BITS = 65536,
    parameter int MAX_HASHES  = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  bfiq_pkg::t_item                i_item,
    output logic                           o_busy,
    input  logic                           i_cfg_we,
    input  logic [bfiq_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bfiq_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                           o_done,
    output bfiq_pkg::t_result              o_result
);

    bfiq_pkg::t_ctrl w_ctrl;
    bfiq_pkg::t_stat w_stat;

    bfiq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl),
        .o_busy  (o_busy)
    );

    bfiq_dp #(
        .FILTER_BITS (FILTER_BITS),
        .MAX_HASHES  (MAX_HASHES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .i_ctrl     (w_ctrl),
        .o_stat     (w_stat),
        .o_done     (o_done),
        .o_result   (o_result)
    );

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(o_busy))
        else $error("result without work in progress");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("two results in a row");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> o_busy)
        else $error("not busy clearing after reset");

    a_count_moves_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_done && !$past(!i_rst_n) |-> $stable(o_result.entry_count) || o_done)
        else $error("entry count changed without a result");

endmodule
